FILE: design/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared widths, byte classification codes, the '?' unit and skip count, and the
// result type of the UTF-8 to 16-bit code unit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

	localparam int BYTE_W = 8;
	localparam int UNIT_W = 16;

	// lead byte classification: (byte & mask) == code
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;

	// code unit given for an unsupported lead byte ('?')
	localparam logic [UNIT_W-1:0] UNKNOWN_CHAR = 16'h003F;

	// continuation bytes left when an unsupported lead byte starts a skip
	localparam logic [1:0] SKIP_COUNT = 2'd3;

	// one result: code unit and end-of-string mark
	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              last;
	} result_t;

endpackage : u8u2_pkg

`default_nettype wire

FILE: design/utf8_to_ucs2_decoder_core.sv
// Results of an accepted byte are registered in the result queue, whose head
// drives the output.
// Throughput: one byte per cycle while the queue has room for two results; a
// terminator that closes a partial sequence yields two code units (3-entry queue).
// Reset: arst_n clears the decode state and empties the result queue at once.
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_core
// Decodes a zero-terminated UTF-8 byte stream into 16-bit code units, with a
// zero code unit marked by tlast at the end of each string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_ucs2_decoder_core
	import u8u2_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte

	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [UNIT_W-1:0]      m_axis_tdata,   // [15:0] code_unit
	output logic                   m_axis_tlast    // last
);

	// The queue must take two results while still holding one: depth three
	// keeps one byte per cycle flowing with one unit waiting at the output.
	localparam int QUEUE_DEPTH = 3;

	// decode state
	logic [1:0]        bytes_left_q;
	logic              skipping_q;
	logic [UNIT_W-1:0] partial_q;

	logic [1:0]        bytes_left_d;
	logic              skipping_d;
	logic [UNIT_W-1:0] partial_d;

	// results of the byte in hand
	logic [1:0]        n_push;
	result_t           res0;
	result_t           res1;

	// result queue, head at entry 0
	result_t           queue_q [QUEUE_DEPTH];
	result_t           queue_d [QUEUE_DEPTH];
	result_t           shifted [QUEUE_DEPTH];
	logic [1:0]        count_q;
	logic [1:0]        count_d;
	logic [1:0]        wr_pos;

	logic              in_fire;
	logic              out_fire;
	logic [UNIT_W-1:0] merged;
	logic [BYTE_W-1:0] b;

	// Accept only while the queue has room for two results.
	assign s_axis_tready = (count_q < 2'(QUEUE_DEPTH - 1));
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = m_axis_tvalid && m_axis_tready;
	assign b             = s_axis_tdata;

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = queue_q[0].code_unit;
	assign m_axis_tlast  = queue_q[0].last;

	// Place the continuation bits: second-to-last byte lands at [11:6], last at [5:0].
	always_comb begin
		if (bytes_left_q == 2'd2) begin
			merged = partial_q | {4'd0, b[5:0], 6'd0};
		end else begin
			merged = partial_q | {10'd0, b[5:0]};
		end
	end

	// Byte decode: next state and up to two results.
	always_comb begin
		bytes_left_d = bytes_left_q;
		skipping_d   = skipping_q;
		partial_d    = partial_q;
		n_push       = 2'd0;
		res0         = '{code_unit: '0, last: 1'b0};
		res1         = '{code_unit: '0, last: 1'b1};

		if (b == '0) begin
			// terminator: flush any open sequence, then the closing zero unit
			if (bytes_left_q != 2'd0 && !skipping_q) begin
				res0   = '{code_unit: partial_q, last: 1'b0};
				n_push = 2'd2;
			end else begin
				res0   = '{code_unit: '0, last: 1'b1};
				n_push = 2'd1;
			end
			bytes_left_d = 2'd0;
			skipping_d   = 1'b0;
			partial_d    = '0;
		end else if (bytes_left_q != 2'd0) begin
			bytes_left_d = bytes_left_q - 2'd1;
			if (skipping_q) begin
				// drop the byte; end the skip on the last one
				if (bytes_left_q == 2'd1) begin
					skipping_d = 1'b0;
				end
			end else if (bytes_left_q == 2'd1) begin
				res0      = '{code_unit: merged, last: 1'b0};
				n_push    = 2'd1;
				partial_d = '0;
			end else begin
				partial_d = merged;
			end
		end else if (!b[BYTE_W-1]) begin
			// plain ASCII passes through
			res0   = '{code_unit: {{(UNIT_W-BYTE_W){1'b0}}, b}, last: 1'b0};
			n_push = 2'd1;
		end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			partial_d    = {5'd0, b[4:0], 6'd0};
			bytes_left_d = 2'd1;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			partial_d    = {b[3:0], 12'd0};
			bytes_left_d = 2'd2;
		end else begin
			// unsupported lead: emit '?' and skip the next three bytes
			res0         = '{code_unit: UNKNOWN_CHAR, last: 1'b0};
			n_push       = 2'd1;
			skipping_d   = 1'b1;
			bytes_left_d = SKIP_COUNT;
			partial_d    = '0;
		end
	end

	// Queue update: advance the head on a pop, then append at the tail.
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			shifted[i] = out_fire ? queue_q[i+1] : queue_q[i];
		end
		shifted[QUEUE_DEPTH-1] = queue_q[QUEUE_DEPTH-1];

		wr_pos = count_q - {1'b0, out_fire};

		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_d[i] = shifted[i];
			if (in_fire && n_push != 2'd0 && 2'(i) == wr_pos) begin
				queue_d[i] = res0;
			end
			if (in_fire && n_push == 2'd2 && 2'(i) == wr_pos + 2'd1) begin
				queue_d[i] = res1;
			end
		end

		count_d = wr_pos + (in_fire ? n_push : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 2'd0;
			skipping_q   <= 1'b0;
			partial_q    <= '0;
			count_q      <= 2'd0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				bytes_left_q <= bytes_left_d;
				skipping_q   <= skipping_d;
				partial_q    <= partial_d;
			end
		end
	end

	// payload: no reset needed, only entries below count_q are ever shown
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_q[i] <= queue_d[i];
		end
	end

endmodule : utf8_to_ucs2_decoder_core

`default_nettype wire

FILE: design/u8u2_checker.sv
// ----------------------------------------------------------------------------
// u8u2_checker
// Port-level checks of the decoder: end-of-string results, backpressure and
// output stability.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_checker
	import u8u2_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic [BYTE_W-1:0] s_axis_tdata,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [UNIT_W-1:0] m_axis_tdata,
	input wire logic              m_axis_tlast
);

	// the end-of-string unit is always zero
	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
		else $error("tlast unit is not zero");

	// a terminator always yields at least one result
	a_term_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata == '0 |=> m_axis_tvalid)
		else $error("terminator accepted but no result pending");

	// input is held off only while results wait
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule : u8u2_checker

bind utf8_to_ucs2_decoder_core u8u2_checker u_u8u2_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
